/* rtl/core/ccbp_pkg.sv */
// ============================================================================
// CIGAR chain block projector package
// Shared codes, item structures and defaults for the chain block projector.
// ============================================================================
package ccbp_pkg;

    // Default position width and command queue depth.
    localparam int POS_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // CIGAR operation codes on the input channel.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_EQ    = 3'd1;
    localparam logic [2:0] OP_X     = 3'd2;
    localparam logic [2:0] OP_INS   = 3'd3;
    localparam logic [2:0] OP_DEL   = 3'd4;
    localparam logic [2:0] OP_M     = 3'd5;
    localparam logic [2:0] OP_END   = 3'd6;

    // Classified command codes handed from the front to the back.
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_MATCH = 3'd1;
    localparam logic [2:0] CMD_INS   = 3'd2;
    localparam logic [2:0] CMD_DEL   = 3'd3;
    localparam logic [2:0] CMD_BAD   = 3'd4;
    localparam logic [2:0] CMD_END   = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_BLOCK = 2'd0;
    localparam logic [1:0] KIND_SPAN  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE        = 2'd0;
    localparam logic [1:0] FAULT_UNSUPPORTED = 2'd1;
    localparam logic [1:0] FAULT_NO_BLOCK    = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW    = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] run_length;
        logic [31:0] ref_start;
        logic [31:0] aln_query_start;
        logic [31:0] aln_query_stop;
        logic [31:0] query_contig_len;
        logic        reverse_strand;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] blk_size;
        logic [31:0] ref_gap;
        logic [31:0] qry_gap;
        logic [31:0] span_ref_first;
        logic [31:0] span_ref_after;
        logic [31:0] span_qry_first;
        logic [31:0] span_qry_after;
        logic [1:0]  fault;
        logic        final_flag;
    } t_out_item;

    // One classified command in the queue.
    typedef struct packed {
        logic [2:0]  code;
        logic        start_fault;
        logic [31:0] len;
        logic [31:0] ref_start;
        logic [31:0] qry_start;
    } t_cmd;

endpackage

/* rtl/core/cigar_chain_block_projector_top.sv */
// ============================================================================
// CIGAR chain block projector
// Converts a stream of CIGAR operations into ungapped chain blocks with their
// gaps, followed by a span summary for each alignment.
// ============================================================================
//
//  Channel   Handshake                  Payload     Direction
//  input     i_in_valid / o_in_ready    i_in_item   one CIGAR item in
//  output    o_out_valid / i_out_ready  o_out_item  one result item out
//
// Flow: an item is taken every cycle while the command queue has room; the
// back end carries out one queued command per cycle unless a held output
// stalls it, and an end item that closes a block stays at the head of the
// queue until it has given both of its result items; results leave through
// the output register. Reset: synchronous and active low; it empties the
// queue and clears the alignment state and the output valid flag.
// Stalls: a full queue drops o_in_ready; a held output stalls only commands
// that give a result, while commands without one keep draining.
//
module cigar_chain_block_projector_top #(
    parameter int POS_WIDTH   = ccbp_pkg::POS_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ccbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ccbp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccbp_pkg::t_out_item o_out_item
);

    // Classified commands travel from the front end through the queue.
    logic           push;
    logic           full;
    logic           pop;
    logic           cmd_valid;
    ccbp_pkg::t_cmd front_cmd;
    ccbp_pkg::t_cmd head_cmd;

    // The front end orients the query start, checks the start positions and
    // drops zero-length runs, which never change the state.
    ccbp_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // The queue lets the input keep flowing while the output is stalled.
    ccbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    // The back end owns the running positions, pending gaps and open block,
    // and registers every result item before it leaves the block.
    ccbp_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/core/ccbp_front.sv */
// ============================================================================
// CIGAR chain block projector front end
// Accepts input items, orients the query start, checks start positions and
// turns each item into a command for the queue.
// ============================================================================
module ccbp_front #(
    parameter int POS_WIDTH = ccbp_pkg::POS_WIDTH_DEF
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ccbp_pkg::t_in_item i_in_item,
    input  logic              i_full,
    output logic              o_push,
    output ccbp_pkg::t_cmd    o_cmd
);

    localparam int SW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;

    logic        keep;
    logic        len_zero;
    logic        stop_past_end;
    logic [31:0] oq;
    logic [SW-1:0] rs_ext;
    logic [SW-1:0] oq_ext;

    assign o_in_ready = !i_full;
    assign len_zero   = (i_in_item.run_length == 32'd0);

    // Oriented query start; the reverse strand counts from the contig end.
    assign stop_past_end = i_in_item.aln_query_stop > i_in_item.query_contig_len;
    assign oq = i_in_item.reverse_strand
              ? (i_in_item.query_contig_len - i_in_item.aln_query_stop)
              : i_in_item.aln_query_start;
    assign rs_ext = SW'(i_in_item.ref_start);
    assign oq_ext = SW'(oq);

    always_comb begin
        o_cmd.code        = ccbp_pkg::CMD_BAD;
        o_cmd.len         = i_in_item.run_length;
        o_cmd.ref_start   = i_in_item.ref_start;
        o_cmd.qry_start   = oq;
        o_cmd.start_fault = 1'b0;
        keep              = !len_zero;
        case (i_in_item.op)
            ccbp_pkg::OP_START: begin
                o_cmd.code        = ccbp_pkg::CMD_START;
                keep              = 1'b1;
                o_cmd.start_fault = (i_in_item.reverse_strand && stop_past_end)
                                  || (|(rs_ext >> POS_WIDTH))
                                  || (|(oq_ext >> POS_WIDTH));
            end
            ccbp_pkg::OP_EQ, ccbp_pkg::OP_X: begin
                o_cmd.code = ccbp_pkg::CMD_MATCH;
            end
            ccbp_pkg::OP_INS: begin
                o_cmd.code = ccbp_pkg::CMD_INS;
            end
            ccbp_pkg::OP_DEL: begin
                o_cmd.code = ccbp_pkg::CMD_DEL;
            end
            ccbp_pkg::OP_END: begin
                o_cmd.code = ccbp_pkg::CMD_END;
                keep       = 1'b1;
            end
            default: begin
                o_cmd.code = ccbp_pkg::CMD_BAD;
            end
        endcase
    end

    // Zero-length runs never change anything, so they are dropped here.
    assign o_push = i_in_valid && o_in_ready && keep;

endmodule

/* rtl/core/ccbp_queue.sv */
// ============================================================================
// CIGAR chain block projector command queue
// Small first-in first-out buffer between the front and back ends.
// ============================================================================
module ccbp_queue #(
    parameter int DEPTH = ccbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccbp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ccbp_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ccbp_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/ccbp_back.sv */
// ============================================================================
// CIGAR chain block projector back end
// Keeps the alignment state, carries out one command per cycle unless a held
// output stalls it, and drives the registered result channel.
// ============================================================================
module ccbp_back #(
    parameter int POS_WIDTH = ccbp_pkg::POS_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ccbp_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccbp_pkg::t_out_item o_out_item
);

    localparam int SW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;

    logic                 r_active, n_active;
    logic                 r_failed, n_failed;
    logic                 r_have_blk, n_have_blk;
    logic                 r_end_half, n_end_half;
    logic [POS_WIDTH-1:0] r_ref_pos, n_ref_pos;
    logic [POS_WIDTH-1:0] r_qry_pos, n_qry_pos;
    logic [POS_WIDTH-1:0] r_pend_ref_gap, n_pend_ref_gap;
    logic [POS_WIDTH-1:0] r_pend_qry_gap, n_pend_qry_gap;
    logic [POS_WIDTH-1:0] r_cur_blk_size, n_cur_blk_size;
    logic [POS_WIDTH-1:0] r_first_ref, n_first_ref;
    logic [POS_WIDTH-1:0] r_first_qry, n_first_qry;
    logic                 r_out_valid;
    ccbp_pkg::t_out_item  r_out, n_out;

    logic                 emit;
    logic                 pop;
    logic                 go;
    logic                 can_load;
    logic [SW-1:0]        sum_ref;
    logic [SW-1:0]        sum_qry;
    logic                 ovf_ref;
    logic                 ovf_qry;
    logic [POS_WIDTH-1:0] len_pos;
    logic [POS_WIDTH-1:0] ref_after;
    logic [POS_WIDTH-1:0] qry_after;

    assign sum_ref   = SW'(r_ref_pos) + SW'(i_cmd.len);
    assign sum_qry   = SW'(r_qry_pos) + SW'(i_cmd.len);
    assign ovf_ref   = |(sum_ref >> POS_WIDTH);
    assign ovf_qry   = |(sum_qry >> POS_WIDTH);
    assign len_pos   = POS_WIDTH'(i_cmd.len);
    assign ref_after = r_ref_pos - r_pend_ref_gap;
    assign qry_after = r_qry_pos - r_pend_qry_gap;

    always_comb begin
        n_active       = r_active;
        n_failed       = r_failed;
        n_have_blk     = r_have_blk;
        n_end_half     = 1'b0;
        n_ref_pos      = r_ref_pos;
        n_qry_pos      = r_qry_pos;
        n_pend_ref_gap = r_pend_ref_gap;
        n_pend_qry_gap = r_pend_qry_gap;
        n_cur_blk_size = r_cur_blk_size;
        n_first_ref    = r_first_ref;
        n_first_qry    = r_first_qry;
        n_out          = '0;
        n_out.kind     = ccbp_pkg::KIND_ERROR;
        n_out.final_flag = 1'b1;
        emit           = 1'b0;
        pop            = 1'b1;

        if (i_cmd.code == ccbp_pkg::CMD_START) begin
            n_active       = 1'b1;
            n_failed       = 1'b0;
            n_have_blk     = 1'b0;
            n_pend_ref_gap = '0;
            n_pend_qry_gap = '0;
            n_cur_blk_size = '0;
            n_first_ref    = '0;
            n_first_qry    = '0;
            if (i_cmd.start_fault) begin
                n_failed    = 1'b1;
                n_ref_pos   = '0;
                n_qry_pos   = '0;
                emit        = 1'b1;
                n_out.fault = ccbp_pkg::FAULT_OVERFLOW;
            end else begin
                n_ref_pos = POS_WIDTH'(i_cmd.ref_start);
                n_qry_pos = POS_WIDTH'(i_cmd.qry_start);
            end
        end else if (r_active && r_failed) begin
            if (i_cmd.code == ccbp_pkg::CMD_END) begin
                n_active = 1'b0;
            end
        end else if (r_active) begin
            case (i_cmd.code)
                ccbp_pkg::CMD_MATCH: begin
                    if (ovf_ref || ovf_qry) begin
                        n_failed    = 1'b1;
                        emit        = 1'b1;
                        n_out.fault = ccbp_pkg::FAULT_OVERFLOW;
                    end else begin
                        if (!r_have_blk) begin
                            n_first_ref    = r_ref_pos;
                            n_first_qry    = r_qry_pos;
                            n_cur_blk_size = len_pos;
                            n_have_blk     = 1'b1;
                        end else if (r_pend_ref_gap == '0 && r_pend_qry_gap == '0) begin
                            n_cur_blk_size = r_cur_blk_size + len_pos;
                        end else begin
                            emit           = 1'b1;
                            n_out.kind     = ccbp_pkg::KIND_BLOCK;
                            n_out.blk_size = 32'(r_cur_blk_size);
                            n_out.ref_gap  = 32'(r_pend_ref_gap);
                            n_out.qry_gap  = 32'(r_pend_qry_gap);
                            n_cur_blk_size = len_pos;
                            n_pend_ref_gap = '0;
                            n_pend_qry_gap = '0;
                        end
                        n_ref_pos = sum_ref[POS_WIDTH-1:0];
                        n_qry_pos = sum_qry[POS_WIDTH-1:0];
                    end
                end
                ccbp_pkg::CMD_INS: begin
                    if (ovf_qry) begin
                        n_failed    = 1'b1;
                        emit        = 1'b1;
                        n_out.fault = ccbp_pkg::FAULT_OVERFLOW;
                    end else begin
                        n_qry_pos = sum_qry[POS_WIDTH-1:0];
                        if (r_have_blk) begin
                            n_pend_qry_gap = r_pend_qry_gap + len_pos;
                        end
                    end
                end
                ccbp_pkg::CMD_DEL: begin
                    if (ovf_ref) begin
                        n_failed    = 1'b1;
                        emit        = 1'b1;
                        n_out.fault = ccbp_pkg::FAULT_OVERFLOW;
                    end else begin
                        n_ref_pos = sum_ref[POS_WIDTH-1:0];
                        if (r_have_blk) begin
                            n_pend_ref_gap = r_pend_ref_gap + len_pos;
                        end
                    end
                end
                ccbp_pkg::CMD_END: begin
                    emit = 1'b1;
                    if (!r_have_blk) begin
                        n_active    = 1'b0;
                        n_failed    = 1'b1;
                        n_out.fault = ccbp_pkg::FAULT_NO_BLOCK;
                    end else if (!r_end_half) begin
                        // First of two results: the final block, without gaps.
                        n_end_half       = 1'b1;
                        pop              = 1'b0;
                        n_out.kind       = ccbp_pkg::KIND_BLOCK;
                        n_out.blk_size   = 32'(r_cur_blk_size);
                        n_out.final_flag = 1'b0;
                    end else begin
                        n_out.kind           = ccbp_pkg::KIND_SPAN;
                        n_out.span_ref_first = 32'(r_first_ref);
                        n_out.span_ref_after = 32'(ref_after);
                        n_out.span_qry_first = 32'(r_first_qry);
                        n_out.span_qry_after = 32'(qry_after);
                        n_have_blk           = 1'b0;
                        n_active             = 1'b0;
                    end
                end
                default: begin
                    n_failed    = 1'b1;
                    emit        = 1'b1;
                    n_out.fault = ccbp_pkg::FAULT_UNSUPPORTED;
                end
            endcase
        end
    end

    // Commands without a result go ahead even while the output is stalled.
    assign can_load    = !r_out_valid || i_out_ready;
    assign go          = i_cmd_valid && (can_load || !emit);
    assign o_pop       = go && pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_failed       <= 1'b0;
            r_have_blk     <= 1'b0;
            r_end_half     <= 1'b0;
            r_ref_pos      <= '0;
            r_qry_pos      <= '0;
            r_pend_ref_gap <= '0;
            r_pend_qry_gap <= '0;
            r_cur_blk_size <= '0;
            r_first_ref    <= '0;
            r_first_qry    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (go) begin
                r_active       <= n_active;
                r_failed       <= n_failed;
                r_have_blk     <= n_have_blk;
                r_end_half     <= n_end_half;
                r_ref_pos      <= n_ref_pos;
                r_qry_pos      <= n_qry_pos;
                r_pend_ref_gap <= n_pend_ref_gap;
                r_pend_qry_gap <= n_pend_qry_gap;
                r_cur_blk_size <= n_cur_blk_size;
                r_first_ref    <= n_first_ref;
                r_first_qry    <= n_first_qry;
            end
            if (go && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out <= n_out;
        end
    end

    // An open block outside a failed alignment always belongs to an active one.
    a_blk_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have_blk && !r_failed) |-> r_active)
        else $error("open block without an active alignment");

    // The second half of an end is pending only with the end still queued.
    a_end_half_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_half |-> (r_active && r_have_blk && !r_failed && i_cmd_valid))
        else $error("end second half pending out of context");

    // Pending gaps only exist after a block has been opened.
    a_gap_needs_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend_ref_gap != '0 || r_pend_qry_gap != '0) && r_active) |-> r_have_blk)
        else $error("pending gap without a block");

    // A non-final result is the final block of an end, which a span follows.
    a_nonfinal_is_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.final_flag) |-> (r_out.kind == ccbp_pkg::KIND_BLOCK
            && r_end_half))
        else $error("non-final result is not an end block");

endmodule

/* tb/sv/tb_cigar_chain_block_projector_top.sv */
// ============================================================================
// CIGAR chain block projector testbench
// Streams directed and random CIGAR alignments into the projector with random
// gaps and output back-pressure. Every accepted item is run through a local
// projection model, and each result item is checked field by field in order.
// ============================================================================
module tb_cigar_chain_block_projector_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The package has no name for op code 7, which the block rejects.
    localparam logic [2:0] OP_RSVD = 3'd7;

    // Positions are checked against the block's default width.
    localparam int          POS_W     = ccbp_pkg::POS_WIDTH_DEF;
    localparam logic [63:0] POS_LIMIT = (64'd1 << POS_W) - 64'd1;

    // The run is cut off here if the results stop coming.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles to linger once nothing is owed, so that stray results show up.
    localparam int DRAIN_CYCLES = 32;

    localparam int RANDOM_ITEMS = 550;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero, since the reset is synchronous.
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    ccbp_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    ccbp_pkg::t_out_item o_out_item;

    always #6 i_clk = ~i_clk;

    cigar_chain_block_projector_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------------
    // Stimulus and expectation stores.
    // ------------------------------------------------------------------------
    ccbp_pkg::t_in_item  cigar_ops_to_send[$];
    ccbp_pkg::t_out_item chain_results_due[$];

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // ------------------------------------------------------------------------
    // Projection model state. Positions are held in 64 bits so that the
    // overflow test can be written without wrapping.
    // ------------------------------------------------------------------------
    logic        aln_active;
    logic        aln_failed;
    logic        blk_open;
    logic [63:0] ref_cursor;
    logic [63:0] qry_cursor;
    logic [63:0] gap_ref_pending;
    logic [63:0] gap_qry_pending;
    logic [63:0] blk_len;
    logic [63:0] blk_ref_first;
    logic [63:0] blk_qry_first;

    function automatic void clear_projection();
        aln_active      = 1'b0;
        aln_failed      = 1'b0;
        blk_open        = 1'b0;
        ref_cursor      = '0;
        qry_cursor      = '0;
        gap_ref_pending = '0;
        gap_qry_pending = '0;
        blk_len         = '0;
        blk_ref_first   = '0;
        blk_qry_first   = '0;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic [63:0] sz, logic [63:0] rg,
                                         logic [63:0] qg, logic [63:0] rf, logic [63:0] ra,
                                         logic [63:0] qf, logic [63:0] qa, logic [1:0] fault,
                                         logic fin);
        ccbp_pkg::t_out_item r;
        r.kind           = kind;
        r.blk_size       = sz[31:0];
        r.ref_gap        = rg[31:0];
        r.qry_gap        = qg[31:0];
        r.span_ref_first = rf[31:0];
        r.span_ref_after = ra[31:0];
        r.span_qry_first = qf[31:0];
        r.span_qry_after = qa[31:0];
        r.fault          = fault;
        r.final_flag     = fin;
        chain_results_due.insert(chain_results_due.size(), r);
    endfunction

    function automatic void flag_fault(logic [1:0] fault);
        aln_failed = 1'b1;
        queue_result(ccbp_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, fault, 1'b1);
    endfunction

    function automatic logic runs_past_limit(logic [63:0] pos, logic [63:0] len);
        return (pos > POS_LIMIT) || (len > POS_LIMIT - pos);
    endfunction

    // Applies one accepted CIGAR item to the model and queues what it yields.
    function automatic void project_cigar_op(ccbp_pkg::t_in_item item);
        logic [63:0] len;
        logic [63:0] oriented_qry;
        len = {32'd0, item.run_length};

        if (item.op == ccbp_pkg::OP_START) begin
            clear_projection();
            aln_active = 1'b1;
            if (item.reverse_strand) begin
                if (item.aln_query_stop > item.query_contig_len) begin
                    flag_fault(ccbp_pkg::FAULT_OVERFLOW);
                    return;
                end
                oriented_qry = {32'd0, item.query_contig_len - item.aln_query_stop};
            end else begin
                oriented_qry = {32'd0, item.aln_query_start};
            end
            ref_cursor = {32'd0, item.ref_start};
            qry_cursor = oriented_qry;
            return;
        end

        if (!aln_active) begin
            return;
        end
        if (aln_failed) begin
            if (item.op == ccbp_pkg::OP_END) begin
                aln_active = 1'b0;
            end
            return;
        end

        case (item.op)
            ccbp_pkg::OP_EQ, ccbp_pkg::OP_X: begin
                if (len == 0) begin
                    return;
                end
                if (runs_past_limit(ref_cursor, len) || runs_past_limit(qry_cursor, len)) begin
                    flag_fault(ccbp_pkg::FAULT_OVERFLOW);
                    return;
                end
                if (!blk_open) begin
                    blk_ref_first = ref_cursor;
                    blk_qry_first = qry_cursor;
                    blk_len       = len;
                    blk_open      = 1'b1;
                end else if (gap_ref_pending == 0 && gap_qry_pending == 0) begin
                    blk_len = blk_len + len;
                end else begin
                    // Gaps separate this run from the open block, so the open
                    // block is closed and goes out with those gaps.
                    queue_result(ccbp_pkg::KIND_BLOCK, blk_len, gap_ref_pending,
                                 gap_qry_pending, '0, '0, '0, '0, ccbp_pkg::FAULT_NONE, 1'b1);
                    blk_len         = len;
                    gap_ref_pending = '0;
                    gap_qry_pending = '0;
                end
                ref_cursor = ref_cursor + len;
                qry_cursor = qry_cursor + len;
            end
            ccbp_pkg::OP_INS: begin
                if (len == 0) begin
                    return;
                end
                if (runs_past_limit(qry_cursor, len)) begin
                    flag_fault(ccbp_pkg::FAULT_OVERFLOW);
                    return;
                end
                qry_cursor = qry_cursor + len;
                if (blk_open) begin
                    gap_qry_pending = gap_qry_pending + len;
                end
            end
            ccbp_pkg::OP_DEL: begin
                if (len == 0) begin
                    return;
                end
                if (runs_past_limit(ref_cursor, len)) begin
                    flag_fault(ccbp_pkg::FAULT_OVERFLOW);
                    return;
                end
                ref_cursor = ref_cursor + len;
                if (blk_open) begin
                    gap_ref_pending = gap_ref_pending + len;
                end
            end
            ccbp_pkg::OP_END: begin
                aln_active = 1'b0;
                if (!blk_open) begin
                    flag_fault(ccbp_pkg::FAULT_NO_BLOCK);
                    return;
                end
                // Trailing gaps are dropped: the span ends after the last block.
                queue_result(ccbp_pkg::KIND_BLOCK, blk_len, '0, '0, '0, '0, '0, '0,
                             ccbp_pkg::FAULT_NONE, 1'b0);
                queue_result(ccbp_pkg::KIND_SPAN, '0, '0, '0, blk_ref_first,
                             ref_cursor - gap_ref_pending, blk_qry_first,
                             qry_cursor - gap_qry_pending, ccbp_pkg::FAULT_NONE, 1'b1);
                blk_open = 1'b0;
            end
            default: begin
                // 'M' and the unused op code are rejected unless empty.
                if (len != 0) begin
                    flag_fault(ccbp_pkg::FAULT_UNSUPPORTED);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders. Fields that an op does not read get random values so
    // that the block is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic void send_op(logic [2:0] op, logic [31:0] len);
        ccbp_pkg::t_in_item item;
        item.op               = op;
        item.run_length       = len;
        item.ref_start        = $urandom();
        item.aln_query_start  = $urandom();
        item.aln_query_stop   = $urandom();
        item.query_contig_len = $urandom();
        item.reverse_strand   = 1'($urandom_range(0, 1));
        cigar_ops_to_send.insert(cigar_ops_to_send.size(), item);
    endfunction

    function automatic void send_start(logic [31:0] rs, logic [31:0] qb, logic [31:0] qe,
                                       logic [31:0] ql, logic rev);
        ccbp_pkg::t_in_item item;
        item.op               = ccbp_pkg::OP_START;
        item.run_length       = $urandom();
        item.ref_start        = rs;
        item.aln_query_start  = qb;
        item.aln_query_stop   = qe;
        item.query_contig_len = ql;
        item.reverse_strand   = rev;
        cigar_ops_to_send.insert(cigar_ops_to_send.size(), item);
    endfunction

    // Mostly short runs; now and then an empty run, a longer one or a full-width
    // one, which usually runs past the position limit.
    function automatic logic [31:0] pick_run_length();
        int roll;
        roll = $urandom_range(0, 39);
        if (roll == 0) begin
            return 32'd0;
        end else if (roll == 1) begin
            return $urandom();
        end else if (roll == 2) begin
            return $urandom_range(1000, 100000);
        end
        return $urandom_range(1, 60);
    endfunction

    // One alignment: a start, a run of CIGAR ops and usually an end, with an
    // occasional bad op or restart mixed in.
    function automatic void send_random_alignment();
        logic [31:0] rs;
        logic [31:0] qb;
        logic [31:0] qe;
        logic [31:0] ql;
        logic        rev;
        int          n_ops;
        int          roll;
        rev  = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            // Anywhere in the 32-bit range, every bit free.
            rs = $urandom();
            ql = $urandom();
            qe = $urandom();
            qb = $urandom();
        end else if (roll == 1) begin
            // Close to the top, so that runs overflow soon.
            rs = 32'hFFFF_FFFF - $urandom_range(0, 300);
            ql = 32'hFFFF_FFFF - $urandom_range(0, 300);
            qe = $urandom_range(0, 300);
            qb = 32'hFFFF_FFFF - $urandom_range(0, 300);
        end else begin
            rs = $urandom_range(0, 1000000);
            ql = $urandom_range(1000, 1000000);
            qe = ql - $urandom_range(0, 999);
            qb = $urandom_range(0, 1000000);
        end
        // A reverse interval that sticks out of its contig now and then.
        if (rev && $urandom_range(0, 14) == 0) begin
            qe = ql + $urandom_range(1, 50);
        end
        send_start(rs, qb, qe, ql, rev);

        n_ops = $urandom_range(1, 10);
        for (int k = 0; k < n_ops; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_op(ccbp_pkg::OP_EQ, pick_run_length());
            end else if (roll < 60) begin
                send_op(ccbp_pkg::OP_X, pick_run_length());
            end else if (roll < 78) begin
                send_op(ccbp_pkg::OP_INS, pick_run_length());
            end else if (roll < 96) begin
                send_op(ccbp_pkg::OP_DEL, pick_run_length());
            end else if (roll < 98) begin
                send_op($urandom_range(0, 1) ? ccbp_pkg::OP_M : OP_RSVD, pick_run_length());
            end else begin
                // A restart in the middle of the alignment.
                send_start($urandom_range(0, 5000), $urandom_range(0, 5000), $urandom(),
                           $urandom(), 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_op(ccbp_pkg::OP_END, $urandom());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Idle draws. Each side draws a random wait before each item, except during
    // calm stretches where it runs back to back.
    // ------------------------------------------------------------------------
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents one item at a time and keeps it steady until accepted.
    // The next valid and payload are worked out first and assigned once, so
    // that a back-to-back item never sees valid lowered and raised in one step.
    // ------------------------------------------------------------------------
    int                 send_wait = 0;
    int                 send_calm = 0;
    logic               send_valid_nxt;
    ccbp_pkg::t_in_item send_item_nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item  <= '0;
            send_wait  = draw_wait(send_calm);
        end else begin
            send_valid_nxt = i_in_valid;
            send_item_nxt  = i_in_item;
            if (i_in_valid && o_in_ready) begin
                project_cigar_op(i_in_item);
                send_valid_nxt = 1'b0;
            end
            if (!send_valid_nxt && cigar_ops_to_send.size() > 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    send_item_nxt  = cigar_ops_to_send.pop_front();
                    send_valid_nxt = 1'b1;
                    send_wait      = draw_wait(send_calm);
                end
            end
            i_in_valid <= send_valid_nxt;
            i_in_item  <= send_item_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results, checks them against the oldest expectation and
    // stalls the output for a random number of cycles after each one.
    // ------------------------------------------------------------------------
    int recv_wait = 0;
    int recv_calm = 0;

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %h, got %h", results_seen, fname, want, got);
            end
        end
    endtask

    task automatic check_result(ccbp_pkg::t_out_item got);
        ccbp_pkg::t_out_item want;
        results_seen++;
        if (chain_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: none expected, got %p", results_seen, got);
            end
            return;
        end
        want = chain_results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("blk_size", want.blk_size, got.blk_size);
        check_field("ref_gap", want.ref_gap, got.ref_gap);
        check_field("qry_gap", want.qry_gap, got.qry_gap);
        check_field("span_ref_first", want.span_ref_first, got.span_ref_first);
        check_field("span_ref_after", want.span_ref_after, got.span_ref_after);
        check_field("span_qry_first", want.span_qry_first, got.span_qry_first);
        check_field("span_qry_after", want.span_qry_after, got.span_qry_after);
        check_field("fault", 32'(want.fault), 32'(got.fault));
        check_field("final_flag", 32'(want.final_flag), 32'(got.final_flag));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait   = draw_wait(recv_calm);
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_item);
                recv_wait = draw_wait(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cigar_chain_block_projector_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed alignments, then random ones, then the drain and
    // the verdict.
    // ------------------------------------------------------------------------
    initial begin
        clear_projection();

        // Ops with no alignment open are ignored.
        send_op(ccbp_pkg::OP_END, 32'd5);
        send_op(ccbp_pkg::OP_INS, 32'hFFFF_FFFF);

        // Forward alignment: empty run, block growth, a gapped block, trailing
        // gaps that must be dropped, then the end with its span.
        send_start(32'd100, 32'd10, 32'd60, 32'd1000, 1'b0);
        send_op(ccbp_pkg::OP_EQ, 32'd0);
        send_op(ccbp_pkg::OP_EQ, 32'd5);
        send_op(ccbp_pkg::OP_X, 32'd3);
        send_op(ccbp_pkg::OP_INS, 32'd2);
        send_op(ccbp_pkg::OP_DEL, 32'd4);
        send_op(ccbp_pkg::OP_EQ, 32'd7);
        send_op(ccbp_pkg::OP_DEL, 32'd3);
        send_op(ccbp_pkg::OP_END, 32'd0);

        // Reverse strand; an empty 'M' is harmless, a real one is an error,
        // after which everything up to the end is ignored.
        send_start(32'd0, 32'd5, 32'd40, 32'd40, 1'b1);
        send_op(ccbp_pkg::OP_M, 32'd0);
        send_op(ccbp_pkg::OP_M, 32'd5);
        send_op(ccbp_pkg::OP_EQ, 32'd4);
        send_op(ccbp_pkg::OP_END, 32'd0);

        // The unused op code, and a reverse interval past the contig end.
        send_start(32'd7, 32'd0, 32'd0, 32'd0, 1'b0);
        send_op(OP_RSVD, 32'd1);
        send_start(32'd0, 32'd0, 32'd50, 32'd49, 1'b1);
        send_op(ccbp_pkg::OP_END, 32'd0);

        // Runs that carry a position past the top.
        send_start(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0);
        send_op(ccbp_pkg::OP_EQ, 32'd1);
        send_start(32'd0, 32'hFFFF_FFF0, 32'd0, 32'd0, 1'b0);
        send_op(ccbp_pkg::OP_INS, 32'd16);

        // An end with no block, and a restart that abandons an alignment.
        send_start(32'd3, 32'd3, 32'd0, 32'd0, 1'b0);
        send_op(ccbp_pkg::OP_END, 32'd0);
        send_start(32'd1, 32'd1, 32'd0, 32'd0, 1'b0);
        send_op(ccbp_pkg::OP_EQ, 32'd3);
        send_start(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_op(ccbp_pkg::OP_EQ, 32'hFFFF_FFFF);
        send_op(ccbp_pkg::OP_END, 32'd0);

        // Random part: mostly well-formed alignments with ignored ops between.
        while (cigar_ops_to_send.size() < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                send_op(3'($urandom_range(1, 7)), $urandom());
            end
            send_random_alignment();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item has gone in and every result has come out.
        while (cigar_ops_to_send.size() > 0 || i_in_valid || chain_results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && chain_results_due.size() == 0) begin
            $display("cigar_chain_block_projector_top test passed");
        end else begin
            $display("cigar_chain_block_projector_top test failed");
        end
        $finish;
    end

endmodule
